// ===== design/rcm_pkg.sv =====
// Shared types and constants of the RTS/CTS/DATA/ACK handshake controller.
package rcm_pkg;

  typedef enum logic [2:0] {
    ST_UNSYNC     = 3'd0,
    ST_IDLE       = 3'd1,
    ST_EXP_CTS    = 3'd2,
    ST_EXP_ACK    = 3'd3,
    ST_EXP_DATA   = 3'd4,
    ST_EXP_PACKET = 3'd5
  } link_state_e;

  typedef enum logic [1:0] {
    SK_RTS  = 2'd0,
    SK_CTS  = 2'd1,
    SK_ACK  = 2'd2,
    SK_DATA = 2'd3
  } send_kind_e;

  typedef enum logic [2:0] {
    EV_TICK = 3'd0,
    EV_RTS  = 3'd1,
    EV_CTS  = 3'd2,
    EV_ACK  = 3'd3,
    EV_DATA = 3'd4,
    EV_NONE = 3'd5
  } ev_class_e;

  localparam logic       ACTION_TICK = 1'b0;
  localparam logic [3:0] FRAME_RTS   = 4'd0;
  localparam logic [3:0] FRAME_CTS   = 4'd1;
  localparam logic [3:0] FRAME_ACK   = 4'd2;
  localparam logic [3:0] FRAME_DATA  = 4'd3;

  localparam logic CFG_NODE_ADDRESS = 1'b0;
  localparam logic CFG_IS_MASTER    = 1'b1;

  localparam int unsigned BCAST_ADDR = 15;

  typedef struct packed {
    ev_class_e cls;
    logic      qne_c1;
    logic      c2;
    logic      busy;
    logic      dest_me;
    logic      net_me;
    logic      pbit;
  } ev_t;

endpackage

// ===== design/rcm_front.sv =====
// Front end: accepts input items and classifies them into handshake events.
module rcm_front import rcm_pkg::*; #(
  parameter int unsigned AddrWidth = 4
) (
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 action_i,
  input  logic                 queue_not_empty_i,
  input  logic [AddrWidth-1:0] head_receiver_i,
  input  logic                 clear_first_i,
  input  logic                 clear_second_i,
  input  logic                 listen_busy_i,
  input  logic [AddrWidth-1:0] frame_dest_i,
  input  logic [AddrWidth-1:0] frame_src_i,
  input  logic [3:0]           frame_type_i,
  input  logic [AddrWidth-1:0] frame_net_receiver_i,
  input  logic                 payload_bit0_i,
  input  logic [AddrWidth-1:0] node_address_i,
  output logic                 ev_valid_o,
  input  logic                 ev_stall_i,
  output ev_t                  ev_o,
  output logic [AddrWidth-1:0] ev_addr_o
);

  localparam logic [AddrWidth-1:0] BcastAddr = AddrWidth'(BCAST_ADDR);

  logic dest_me;
  logic hit;

  assign ev_valid_o = in_valid_i;
  assign in_stall_o = ev_stall_i;
  assign dest_me    = (frame_dest_i == node_address_i);
  assign hit        = dest_me || (frame_dest_i == BcastAddr);

  always_comb begin
    ev_o.qne_c1  = queue_not_empty_i & clear_first_i;
    ev_o.c2      = clear_second_i;
    ev_o.busy    = listen_busy_i;
    ev_o.dest_me = dest_me;
    ev_o.net_me  = (frame_net_receiver_i == node_address_i);
    ev_o.pbit    = payload_bit0_i;
    ev_addr_o    = (action_i == ACTION_TICK) ? head_receiver_i : frame_src_i;
    if (action_i == ACTION_TICK) begin
      ev_o.cls = EV_TICK;
    end else if (!hit) begin
      ev_o.cls = EV_NONE;
    end else begin
      unique case (frame_type_i)
        FRAME_RTS:  ev_o.cls = EV_RTS;
        FRAME_CTS:  ev_o.cls = EV_CTS;
        FRAME_ACK:  ev_o.cls = EV_ACK;
        FRAME_DATA: ev_o.cls = EV_DATA;
        default:    ev_o.cls = EV_NONE;
      endcase
    end
  end

endmodule

// ===== design/rcm_fifo.sv =====
// Two-entry event queue between the front end and the handshake engine.
module rcm_fifo #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_stall_o,
  input  logic [Width-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_stall_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [2];
  logic [1:0]       count_q, count_d;
  logic             wptr_q, rptr_q;
  logic             push, pop;

  assign wr_stall_o = (count_q == 2'd2);
  assign rd_valid_o = (count_q != 2'd0);
  assign rd_data_o  = mem_q[rptr_q];
  assign push       = wr_valid_i && !wr_stall_o;
  assign pop        = rd_valid_o && !rd_stall_i;

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wptr_q <= ~wptr_q;
      end
      if (pop) begin
        rptr_q <= ~rptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

endmodule

// ===== design/rcm_back.sv =====
// Handshake engine: link state, partner address, configuration and result register.
module rcm_back import rcm_pkg::*; #(
  parameter int unsigned AddrWidth = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_index_i,
  input  logic [AddrWidth-1:0] cfg_data_i,
  output logic [AddrWidth-1:0] node_address_o,
  input  logic                 ev_valid_i,
  output logic                 ev_stall_o,
  input  ev_t                  ev_i,
  input  logic [AddrWidth-1:0] ev_addr_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 send_valid_o,
  output logic [1:0]           send_kind_o,
  output logic [AddrWidth-1:0] send_dest_o,
  output logic                 dequeue_o,
  output logic                 deliver_o,
  output logic                 deliver_bit_o,
  output logic                 forward_o,
  output logic                 resync_timer_o,
  output logic [2:0]           mac_state_o
);

  link_state_e          state_q, state_d;
  logic [AddrWidth-1:0] partner_q, partner_d;
  logic [AddrWidth-1:0] node_address_q;
  logic                 is_master_q;
  logic                 out_valid_q;
  logic                 pop, cfg_we;
  logic                 partner_hit;

  logic                 sv_d, deq_d, dlv_d, dbit_d, fwd_d, rs_d;
  send_kind_e           sk_d;
  logic [AddrWidth-1:0] sd_d;

  logic                 sv_q, deq_q, dlv_q, dbit_q, fwd_q, rs_q;
  logic [1:0]           sk_q;
  logic [AddrWidth-1:0] sd_q;
  logic [2:0]           ms_q;

  assign cfg_ready_o    = 1'b1;
  assign cfg_we         = cfg_valid_i && cfg_ready_o;
  assign node_address_o = node_address_q;
  assign ev_stall_o     = out_valid_q && out_stall_i;
  assign pop            = ev_valid_i && !ev_stall_o;
  assign partner_hit    = (partner_q == ev_addr_i);

  // next state
  always_comb begin
    state_d   = state_q;
    partner_d = partner_q;
    if (pop) begin
      unique case (ev_i.cls) inside
        EV_TICK: begin
          if (state_q != ST_UNSYNC) begin
            if (ev_i.qne_c1) begin
              partner_d = ev_addr_i;
            end
            if (ev_i.qne_c1 && ev_i.c2) begin
              state_d = ST_EXP_CTS;
            end else if (ev_i.busy) begin
              state_d = ST_EXP_PACKET;
            end else begin
              state_d = ST_IDLE;
            end
          end
        end
        EV_RTS: begin
          if ((state_q == ST_EXP_PACKET || state_q == ST_UNSYNC) && ev_i.dest_me) begin
            partner_d = ev_addr_i;
            state_d   = ST_EXP_DATA;
          end else begin
            state_d = ST_IDLE;
          end
        end
        EV_CTS: begin
          state_d = (state_q == ST_EXP_CTS && partner_hit) ? ST_EXP_ACK : ST_IDLE;
        end
        EV_ACK, EV_DATA: state_d = ST_IDLE;
        default: state_d = state_q;
      endcase
    end else if (cfg_we && cfg_index_i == CFG_IS_MASTER && cfg_data_i[0] &&
                 state_q == ST_UNSYNC) begin
      state_d = ST_IDLE;
    end
  end

  // result fields
  always_comb begin
    sv_d   = 1'b0;
    sk_d   = SK_RTS;
    sd_d   = '0;
    deq_d  = 1'b0;
    dlv_d  = 1'b0;
    dbit_d = 1'b0;
    fwd_d  = 1'b0;
    rs_d   = 1'b0;
    unique case (ev_i.cls)
      EV_TICK: begin
        if (state_q != ST_UNSYNC && ev_i.qne_c1 && ev_i.c2) begin
          sv_d = 1'b1;
          sk_d = SK_RTS;
          sd_d = ev_addr_i;
        end
      end
      EV_RTS: begin
        rs_d = !is_master_q && state_q == ST_UNSYNC;
        if ((state_q == ST_EXP_PACKET || state_q == ST_UNSYNC) && ev_i.dest_me) begin
          sv_d = 1'b1;
          sk_d = SK_CTS;
          sd_d = ev_addr_i;
        end
      end
      EV_CTS: begin
        if (state_q == ST_EXP_CTS && partner_hit) begin
          sv_d = 1'b1;
          sk_d = SK_DATA;
          sd_d = partner_q;
        end
      end
      EV_ACK: begin
        deq_d = state_q == ST_EXP_ACK && partner_hit;
      end
      EV_DATA: begin
        if (state_q == ST_EXP_DATA && partner_hit) begin
          sv_d   = 1'b1;
          sk_d   = SK_ACK;
          sd_d   = ev_addr_i;
          dlv_d  = ev_i.net_me;
          dbit_d = ev_i.net_me & ev_i.pbit;
          fwd_d  = !ev_i.net_me;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_UNSYNC;
      partner_q      <= '0;
      node_address_q <= '0;
      is_master_q    <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      partner_q <= partner_d;
      if (cfg_we && cfg_index_i == CFG_NODE_ADDRESS) begin
        node_address_q <= cfg_data_i;
      end
      if (cfg_we && cfg_index_i == CFG_IS_MASTER) begin
        is_master_q <= cfg_data_i[0];
      end
      if (pop) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      sv_q   <= sv_d;
      sk_q   <= sk_d;
      sd_q   <= sd_d;
      deq_q  <= deq_d;
      dlv_q  <= dlv_d;
      dbit_q <= dbit_d;
      fwd_q  <= fwd_d;
      rs_q   <= rs_d;
      ms_q   <= state_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign send_valid_o   = sv_q;
  assign send_kind_o    = sk_q;
  assign send_dest_o    = sd_q;
  assign dequeue_o      = deq_q;
  assign deliver_o      = dlv_q;
  assign deliver_bit_o  = dbit_q;
  assign forward_o      = fwd_q;
  assign resync_timer_o = rs_q;
  assign mac_state_o    = ms_q;

endmodule

// ===== design/rts_cts_mac_handshake.sv =====
// Top level of the RTS/CTS/DATA/ACK link-layer handshake controller.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------------------
//   in      | input     | in_valid_i/in_stall_o   | tick status or frame header
//   out     | output    | out_valid_o/out_stall_i | send request, flags, mac_state
//   cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One item per cycle sustained while the output is not stalled; a result is
// registered (the accepting edge loads the event queue, and the result register
// is loaded when the engine pops the item). The event queue holds two items.
// Reset clears link state to unsynchronized, partner and node address to zero.
// A stalled output holds the result register and backs up into the queue.
module rts_cts_mac_handshake import rcm_pkg::*; #(
  parameter int unsigned ADDRESS_WIDTH = 4
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic                     cfg_index_i,
  input  logic [ADDRESS_WIDTH-1:0] cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     action_i,
  input  logic                     queue_not_empty_i,
  input  logic [ADDRESS_WIDTH-1:0] head_receiver_i,
  input  logic                     clear_first_i,
  input  logic                     clear_second_i,
  input  logic                     listen_busy_i,
  input  logic [ADDRESS_WIDTH-1:0] frame_dest_i,
  input  logic [ADDRESS_WIDTH-1:0] frame_src_i,
  input  logic [3:0]               frame_type_i,
  input  logic [ADDRESS_WIDTH-1:0] frame_net_receiver_i,
  input  logic                     payload_bit0_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     send_valid_o,
  output logic [1:0]               send_kind_o,
  output logic [ADDRESS_WIDTH-1:0] send_dest_o,
  output logic                     dequeue_o,
  output logic                     deliver_o,
  output logic                     deliver_bit_o,
  output logic                     forward_o,
  output logic                     resync_timer_o,
  output logic [2:0]               mac_state_o
);

  localparam int unsigned QWidth = $bits(ev_t) + ADDRESS_WIDTH;

  logic [ADDRESS_WIDTH-1:0] node_address;
  logic                     fe_valid, fe_stall;
  ev_t                      fe_ev;
  logic [ADDRESS_WIDTH-1:0] fe_addr;
  logic                     be_valid, be_stall;
  ev_t                      be_ev;
  logic [ADDRESS_WIDTH-1:0] be_addr;
  logic [QWidth-1:0]        q_wdata, q_rdata;

  rcm_front #(.AddrWidth(ADDRESS_WIDTH)) u_front (
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .action_i            (action_i),
    .queue_not_empty_i   (queue_not_empty_i),
    .head_receiver_i     (head_receiver_i),
    .clear_first_i       (clear_first_i),
    .clear_second_i      (clear_second_i),
    .listen_busy_i       (listen_busy_i),
    .frame_dest_i        (frame_dest_i),
    .frame_src_i         (frame_src_i),
    .frame_type_i        (frame_type_i),
    .frame_net_receiver_i(frame_net_receiver_i),
    .payload_bit0_i      (payload_bit0_i),
    .node_address_i      (node_address),
    .ev_valid_o          (fe_valid),
    .ev_stall_i          (fe_stall),
    .ev_o                (fe_ev),
    .ev_addr_o           (fe_addr)
  );

  assign q_wdata = {fe_ev, fe_addr};

  rcm_fifo #(.Width(QWidth)) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(fe_valid),
    .wr_stall_o(fe_stall),
    .wr_data_i (q_wdata),
    .rd_valid_o(be_valid),
    .rd_stall_i(be_stall),
    .rd_data_o (q_rdata)
  );

  assign be_ev   = ev_t'(q_rdata[QWidth-1:ADDRESS_WIDTH]);
  assign be_addr = q_rdata[ADDRESS_WIDTH-1:0];

  rcm_back #(.AddrWidth(ADDRESS_WIDTH)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .node_address_o(node_address),
    .ev_valid_i    (be_valid),
    .ev_stall_o    (be_stall),
    .ev_i          (be_ev),
    .ev_addr_i     (be_addr),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .send_valid_o  (send_valid_o),
    .send_kind_o   (send_kind_o),
    .send_dest_o   (send_dest_o),
    .dequeue_o     (dequeue_o),
    .deliver_o     (deliver_o),
    .deliver_bit_o (deliver_bit_o),
    .forward_o     (forward_o),
    .resync_timer_o(resync_timer_o),
    .mac_state_o   (mac_state_o)
  );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the RTS/CTS/DATA/ACK link-layer handshake controller.
module testbench import rcm_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned AW          = 4;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic          action;
    logic          qne;
    logic [AW-1:0] head;
    logic          c1;
    logic          c2;
    logic          busy;
    logic [AW-1:0] fdst;
    logic [AW-1:0] fsrc;
    logic [3:0]    ftype;
    logic [AW-1:0] fnet;
    logic          pbit;
  } mac_event_t;

  typedef struct packed {
    logic          sv;
    send_kind_e    sk;
    logic [AW-1:0] sd;
    logic          deq;
    logic          dlv;
    logic          dbit;
    logic          fwd;
    logic          rs;
    link_state_e   st;
  } mac_result_t;

  localparam int unsigned EV_BITS = $bits(mac_event_t);

  logic          clk;
  logic          rst_ni    = 1'b0;
  logic          cfg_valid = 1'b0;
  logic          cfg_index = 1'b0;
  logic [AW-1:0] cfg_data  = '0;
  logic          in_valid  = 1'b0;
  logic          out_stall = 1'b0;
  mac_event_t    drv       = '0;

  logic          cfg_ready_o;
  logic          in_stall_o;
  logic          out_valid_o;
  logic          send_valid_o;
  logic [1:0]    send_kind_o;
  logic [AW-1:0] send_dest_o;
  logic          dequeue_o;
  logic          deliver_o;
  logic          deliver_bit_o;
  logic          forward_o;
  logic          resync_timer_o;
  logic [2:0]    mac_state_o;

  // predictor state
  link_state_e   lnk_state   = ST_UNSYNC;
  logic [AW-1:0] partner     = '0;
  logic [AW-1:0] node_addr   = '0;
  logic          master_cfg  = 1'b0;

  mac_result_t   pending_results[$];
  int unsigned   mismatches  = 0;
  int unsigned   items_sent  = 0;
  int unsigned   cycle_count = 0;
  bit            tx_idle     = 1'b0;
  bit            rx_idle     = 1'b0;
  int unsigned   rx_hold     = 0;

  rts_cts_mac_handshake #(.ADDRESS_WIDTH(AW)) u_top (
    .clk_i               (clk),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall_o),
    .action_i            (drv.action),
    .queue_not_empty_i   (drv.qne),
    .head_receiver_i     (drv.head),
    .clear_first_i       (drv.c1),
    .clear_second_i      (drv.c2),
    .listen_busy_i       (drv.busy),
    .frame_dest_i        (drv.fdst),
    .frame_src_i         (drv.fsrc),
    .frame_type_i        (drv.ftype),
    .frame_net_receiver_i(drv.fnet),
    .payload_bit0_i      (drv.pbit),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall),
    .send_valid_o        (send_valid_o),
    .send_kind_o         (send_kind_o),
    .send_dest_o         (send_dest_o),
    .dequeue_o           (dequeue_o),
    .deliver_o           (deliver_o),
    .deliver_bit_o       (deliver_bit_o),
    .forward_o           (forward_o),
    .resync_timer_o      (resync_timer_o),
    .mac_state_o         (mac_state_o)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic mac_result_t predict_link(input mac_event_t ev);
    mac_result_t r;
    r = '0;
    r.sk = SK_RTS;
    if (ev.action == ACTION_TICK) begin
      if (lnk_state != ST_UNSYNC) begin
        lnk_state = ST_IDLE;
        if (ev.qne && ev.c1) begin
          partner = ev.head;
          if (ev.c2) begin
            r.sv = 1'b1;
            r.sk = SK_RTS;
            r.sd = partner;
            lnk_state = ST_EXP_CTS;
          end
        end
        if (lnk_state == ST_IDLE && ev.busy) lnk_state = ST_EXP_PACKET;
      end
    end else if (ev.fdst == node_addr || ev.fdst == BCAST_ADDR) begin
      case (ev.ftype)
        FRAME_RTS: begin
          if (!master_cfg && lnk_state == ST_UNSYNC) r.rs = 1'b1;
          if ((lnk_state == ST_EXP_PACKET || lnk_state == ST_UNSYNC) &&
              ev.fdst == node_addr) begin
            r.sv = 1'b1;
            r.sk = SK_CTS;
            r.sd = ev.fsrc;
            partner = ev.fsrc;
            lnk_state = ST_EXP_DATA;
          end else begin
            lnk_state = ST_IDLE;
          end
        end
        FRAME_CTS: begin
          if (lnk_state == ST_EXP_CTS && partner == ev.fsrc) begin
            r.sv = 1'b1;
            r.sk = SK_DATA;
            r.sd = partner;
            lnk_state = ST_EXP_ACK;
          end else begin
            lnk_state = ST_IDLE;
          end
        end
        FRAME_ACK: begin
          if (lnk_state == ST_EXP_ACK && partner == ev.fsrc) r.deq = 1'b1;
          lnk_state = ST_IDLE;
        end
        FRAME_DATA: begin
          if (lnk_state == ST_EXP_DATA && partner == ev.fsrc) begin
            r.sv = 1'b1;
            r.sk = SK_ACK;
            r.sd = ev.fsrc;
            if (ev.fnet == node_addr) begin
              r.dlv  = 1'b1;
              r.dbit = ev.pbit;
            end else begin
              r.fwd = 1'b1;
            end
          end
          lnk_state = ST_IDLE;
        end
        default: ;
      endcase
    end
    r.st = lnk_state;
    return r;
  endfunction

  always @(posedge clk) begin : check_results
    mac_result_t got;
    mac_result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall) begin
      got = '{send_valid_o, send_kind_e'(send_kind_o), send_dest_o, dequeue_o, deliver_o,
              deliver_bit_o, forward_o, resync_timer_o, link_state_e'(mac_state_o)};
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer");
        mismatches++;
      end else begin
        exp_r = pending_results.pop_front();
        if (got.sv !== exp_r.sv) begin
          $error("send_valid: expected %0d, got %0d", exp_r.sv, got.sv);
          mismatches++;
        end
        if (got.sk !== exp_r.sk) begin
          $error("send_kind: expected %0d, got %0d", exp_r.sk, got.sk);
          mismatches++;
        end
        if (got.sd !== exp_r.sd) begin
          $error("send_dest: expected %0d, got %0d", exp_r.sd, got.sd);
          mismatches++;
        end
        if (got.deq !== exp_r.deq) begin
          $error("dequeue: expected %0d, got %0d", exp_r.deq, got.deq);
          mismatches++;
        end
        if (got.dlv !== exp_r.dlv) begin
          $error("deliver: expected %0d, got %0d", exp_r.dlv, got.dlv);
          mismatches++;
        end
        if (got.dbit !== exp_r.dbit) begin
          $error("deliver_bit: expected %0d, got %0d", exp_r.dbit, got.dbit);
          mismatches++;
        end
        if (got.fwd !== exp_r.fwd) begin
          $error("forward: expected %0d, got %0d", exp_r.fwd, got.fwd);
          mismatches++;
        end
        if (got.rs !== exp_r.rs) begin
          $error("resync_timer: expected %0d, got %0d", exp_r.rs, got.rs);
          mismatches++;
        end
        if (got.st !== exp_r.st) begin
          $error("mac_state: expected %0d, got %0d", exp_r.st, got.st);
          mismatches++;
        end
      end
    end
  end

  // result side: random stall per transfer when rx_idle is set, or one long hold when requested
  initial begin : result_stall
    int unsigned n;
    forever begin
      if (rx_hold != 0) begin
        out_stall <= 1'b1;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
        out_stall <= 1'b0;
      end else if (rx_idle) begin
        n = $urandom_range(13, 0);
        if (n != 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
      do @(posedge clk); while (!out_valid_o);
    end
  end

  task automatic send_item(input mac_event_t ev);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(13, 0) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    drv      <= ev;
    do @(posedge clk); while (in_stall_o);
    pending_results.push_back(predict_link(ev));
    items_sent++;
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [AW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    if (idx == CFG_NODE_ADDRESS) begin
      node_addr = data;
    end else begin
      master_cfg = data[0];
      if (master_cfg && lnk_state == ST_UNSYNC) lnk_state = ST_IDLE;
    end
    @(posedge clk);
  endtask

  function automatic mac_event_t rand_event();
    mac_event_t e;
    e = mac_event_t'(EV_BITS'($urandom));
    return e;
  endfunction

  function automatic mac_event_t tick_ev(input logic qne, input logic [AW-1:0] head,
                                         input logic c1, input logic c2, input logic busy);
    mac_event_t e;
    e = rand_event();
    e.action = ACTION_TICK;
    e.qne    = qne;
    e.head   = head;
    e.c1     = c1;
    e.c2     = c2;
    e.busy   = busy;
    return e;
  endfunction

  function automatic mac_event_t frame_ev(input logic [AW-1:0] dst, input logic [AW-1:0] src,
                                          input logic [3:0] ftype, input logic [AW-1:0] net,
                                          input logic pbit);
    mac_event_t e;
    e = rand_event();
    e.action = ~ACTION_TICK;
    e.fdst   = dst;
    e.fsrc   = src;
    e.ftype  = ftype;
    e.fnet   = net;
    e.pbit   = pbit;
    return e;
  endfunction

  function automatic logic [AW-1:0] pick_dest();
    return ($urandom_range(3, 0) == 0) ? AW'(BCAST_ADDR) : node_addr;
  endfunction

  function automatic logic [AW-1:0] maybe_wrong(input logic [AW-1:0] peer);
    return ($urandom_range(7, 0) == 0) ? AW'($urandom) : peer;
  endfunction

  task automatic run_handshake();
    mac_event_t    e;
    logic [AW-1:0] peer;
    int unsigned   pick;
    peer = AW'($urandom);
    pick = $urandom_range(9, 0);
    if (pick <= 3) begin
      send_item(tick_ev(1'b1, peer, 1'b1, 1'b1, 1'($urandom)));
      if ($urandom_range(7, 0) != 0)
        send_item(frame_ev(pick_dest(), maybe_wrong(peer), FRAME_CTS, AW'($urandom),
                           1'($urandom)));
      if ($urandom_range(7, 0) != 0)
        send_item(frame_ev(pick_dest(), maybe_wrong(peer), FRAME_ACK, AW'($urandom),
                           1'($urandom)));
    end else if (pick <= 6) begin
      send_item(tick_ev(1'($urandom), AW'($urandom), 1'($urandom), 1'b0,
                        ($urandom_range(7, 0) != 0)));
      send_item(frame_ev(($urandom_range(7, 0) == 0) ? pick_dest() : node_addr, peer,
                         FRAME_RTS, AW'($urandom), 1'($urandom)));
      if ($urandom_range(7, 0) != 0)
        send_item(frame_ev(pick_dest(), maybe_wrong(peer), FRAME_DATA,
                           $urandom_range(1, 0) ? node_addr : AW'($urandom), 1'($urandom)));
    end else if (pick == 7) begin
      e = rand_event();
      e.action = ACTION_TICK;
      send_item(e);
    end else begin
      e = rand_event();
      if ($urandom_range(2, 0) != 0) e.fdst = pick_dest();
      send_item(e);
    end
  endtask

  task automatic test_unsync_start();
    write_register(CFG_NODE_ADDRESS, 4'd5);
    write_register(CFG_IS_MASTER, 4'b1110);
    send_item(tick_ev(1'b1, 4'hF, 1'b1, 1'b1, 1'b1));
    send_item(frame_ev(4'd5, 4'd9, 4'd12, 4'd0, 1'b1));
    send_item(frame_ev(4'd5, 4'd9, 4'd15, 4'd5, 1'b1));
    send_item(frame_ev(4'd3, 4'd9, FRAME_RTS, 4'd5, 1'b1));
    send_item(frame_ev(4'd5, 4'd9, FRAME_RTS, 4'd0, 1'b0));
    send_item(frame_ev(4'd5, 4'd9, FRAME_DATA, 4'd5, 1'b1));
    wait_all_results();
  endtask

  task automatic test_directed_handshakes();
    send_item(tick_ev(1'b1, 4'hF, 1'b1, 1'b1, 1'b0));
    send_item(frame_ev(4'd5, 4'hF, FRAME_CTS, 4'd0, 1'b0));
    send_item(frame_ev(4'd5, 4'hF, FRAME_ACK, 4'd0, 1'b0));
    send_item(tick_ev(1'b1, 4'd0, 1'b1, 1'b0, 1'b1));
    send_item(frame_ev(4'hF, 4'd2, FRAME_RTS, 4'd0, 1'b0));
    send_item(tick_ev(1'b0, 4'd0, 1'b0, 1'b0, 1'b1));
    send_item(frame_ev(4'd5, 4'd0, FRAME_RTS, 4'd0, 1'b0));
    send_item(frame_ev(4'hF, 4'd0, FRAME_DATA, 4'd9, 1'b1));
    send_item(frame_ev(4'd5, 4'd3, FRAME_CTS, 4'd0, 1'b0));
    send_item(tick_ev(1'b1, 4'd3, 1'b1, 1'b1, 1'b0));
    send_item(frame_ev(4'd5, 4'd4, FRAME_CTS, 4'd0, 1'b0));
    send_item(tick_ev(1'b1, 4'd3, 1'b1, 1'b1, 1'b1));
    send_item(frame_ev(4'd5, 4'd3, FRAME_CTS, 4'd0, 1'b0));
    send_item(frame_ev(4'd5, 4'd4, FRAME_ACK, 4'd0, 1'b0));
    wait_all_results();
    write_register(CFG_NODE_ADDRESS, 4'hF);
    write_register(CFG_IS_MASTER, 4'b0001);
    send_item(frame_ev(4'hF, 4'd0, FRAME_RTS, 4'd0, 1'b0));
    send_item(tick_ev(1'b0, 4'd0, 1'b0, 1'b0, 1'b1));
    send_item(frame_ev(4'hF, 4'd0, FRAME_RTS, 4'hF, 1'b1));
    send_item(frame_ev(4'hF, 4'd0, FRAME_DATA, 4'hF, 1'b0));
    send_item(tick_ev(1'b0, 4'd0, 1'b0, 1'b0, 1'b0));
    wait_all_results();
  endtask

  task automatic test_random_traffic(input logic [AW-1:0] node, input logic master,
                                     input bit txi, input bit rxi, input int unsigned count);
    int unsigned start;
    write_register(CFG_NODE_ADDRESS, node);
    write_register(CFG_IS_MASTER, {(AW-1)'($urandom), master});
    tx_idle = txi;
    rx_idle = rxi;
    start   = items_sent;
    while (items_sent - start < count) run_handshake();
    wait_all_results();
  endtask

  task automatic test_backpressure();
    int unsigned start;
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    rx_hold = 300;
    start   = items_sent;
    while (items_sent - start < 30) run_handshake();
    wait_all_results();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    start   = items_sent;
    while (items_sent - start < 10) run_handshake();
    wait_all_results();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);
    test_unsync_start();
    test_directed_handshakes();
    test_random_traffic(AW'($urandom), 1'b0, 1'b1, 1'b1, 125);
    test_random_traffic(4'hF, 1'b1, 1'b1, 1'b0, 125);
    test_random_traffic(4'd0, 1'b0, 1'b0, 1'b1, 125);
    test_random_traffic(AW'($urandom), 1'b1, 1'b0, 1'b0, 125);
    test_random_traffic(AW'($urandom), 1'b0, 1'b1, 1'b1, 125);
    test_backpressure();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/rcm_pkg.sv
design/rcm_front.sv
design/rcm_fifo.sv
design/rcm_back.sv
design/rts_cts_mac_handshake.sv
tb/testbench.sv
